// ===== hdl/vtm_pkg.sv =====
// Shared widths, register indexes and the tetrahedron corner table of the voxel mesher.
package vtm_pkg;

	// Default for the largest grid side along any axis.
	localparam int MAX_SIDE_DEF = 1024;

	// Field widths of the configuration registers and the record fields.
	localparam int CNT_W   = 11;
	localparam int SPC_W   = 24;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;
	localparam int GRAIN_W = 32;
	localparam int RIDX_W  = 33;
	localparam int NODE_W  = 31;
	localparam int POS_W   = 36;

	// Internal widths: one lattice plane, the voxel number and the multiplier operands.
	localparam int PLANE_W = 21;
	localparam int VOX_W   = 30;
	localparam int MUL_A_W = 21;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Records per voxel and the count of vertex records at its start.
	localparam int REC_PER_VOXEL = 14;
	localparam int VERTS_PER_VOXEL = 8;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_X_COUNT   = 3'd0;
	localparam logic [IDX_W-1:0] REG_Y_COUNT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_Z_COUNT   = 3'd2;
	localparam logic [IDX_W-1:0] REG_X_SPACING = 3'd3;
	localparam logic [IDX_W-1:0] REG_Y_SPACING = 3'd4;
	localparam logic [IDX_W-1:0] REG_Z_SPACING = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [CNT_W-1:0] COUNT_RST   = 11'd1;
	localparam logic [SPC_W-1:0] SPACING_RST = 24'd65536;

	// Record kinds.
	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_TET    = 1'b1;

	// Corner number of slot f of tetrahedron t; all six share the diagonal from corner 1 to 6.
	function automatic logic [2:0] tet_corner(input logic [2:0] t, input logic [1:0] f);
		logic [11:0] row;
		case (t)
			3'd0:    row = {3'd0, 3'd1, 3'd2, 3'd6};
			3'd1:    row = {3'd1, 3'd3, 3'd2, 3'd6};
			3'd2:    row = {3'd0, 3'd1, 3'd6, 3'd4};
			3'd3:    row = {3'd1, 3'd3, 3'd6, 3'd7};
			3'd4:    row = {3'd1, 3'd4, 3'd5, 3'd6};
			3'd5:    row = {3'd5, 3'd7, 3'd1, 3'd6};
			default: row = '0;
		endcase
		case (f)
			2'd0:    return row[11:9];
			2'd1:    return row[8:6];
			2'd2:    return row[5:3];
			default: return row[2:0];
		endcase
	endfunction

endpackage

// ===== hdl/vtm_mul.sv =====
// Shared unsigned multiplier with a registered product.
module vtm_mul (
	input  logic                         clk,
	input  logic [vtm_pkg::MUL_A_W-1:0]  a,
	input  logic [vtm_pkg::MUL_B_W-1:0]  b,
	output logic [vtm_pkg::MUL_P_W-1:0]  prod
);

	// One product per cycle, available on the next cycle.
	always_ff @(posedge clk) begin
		prod <= vtm_pkg::MUL_P_W'(a) * vtm_pkg::MUL_P_W'(b);
	end

endmodule

// ===== hdl/voxel_to_tetrahedra_mesher_unit.sv =====
// Top level of the voxel mesher: scan counters, multiply sequencer and record output.
// The block takes one grain id per voxel in raster order (x fastest, then y, then z) and
// answers each with fourteen records: the eight corner vertices of the voxel, corner n with
// bit 0 for +x, bit 1 for +y and bit 2 for +z, then the six tetrahedra that split the cube
// along the diagonal from corner 1 to corner 6. Vertex coordinates are (2p-1)*spacing in
// units of 2^-17, and shared vertices are sent again for every voxel that touches them.
// One voxel at a time occupies the block: it takes the item, then a single multiplier
// works out the lattice plane sizes, the node and voxel bases and the three coordinate
// products one after another, and then the fourteen records go out, one record per cycle
// while the output is not stalled. in_stall stays high from the take until the last
// record is loaded. A count of zero acts as one, a count above MAX_SIDE acts as MAX_SIDE,
// and any write to a listed register restarts the scan at voxel (0,0,0); writes are taken
// only while the block is idle.
module voxel_to_tetrahedra_mesher_unit #(
	parameter int MAX_SIDE = vtm_pkg::MAX_SIDE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [vtm_pkg::IDX_W-1:0]         cfg_index,
	input  logic [vtm_pkg::CFG_W-1:0]         cfg_data,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [vtm_pkg::GRAIN_W-1:0] grain_label,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              record_kind,
	output logic [vtm_pkg::RIDX_W-1:0]        record_index,
	output logic [vtm_pkg::NODE_W-1:0]        corner_a,
	output logic [vtm_pkg::NODE_W-1:0]        corner_b,
	output logic [vtm_pkg::NODE_W-1:0]        corner_c,
	output logic [vtm_pkg::NODE_W-1:0]        corner_d,
	output logic signed [vtm_pkg::POS_W-1:0]  pos_x,
	output logic signed [vtm_pkg::POS_W-1:0]  pos_y,
	output logic signed [vtm_pkg::POS_W-1:0]  pos_z,
	output logic signed [vtm_pkg::GRAIN_W-1:0] tet_grain,
	output logic                              last_of_voxel
);

	localparam int PW   = $clog2(MAX_SIDE);
	localparam int CW   = PW + 1;
	localparam int MAW  = vtm_pkg::MUL_A_W;
	localparam int MBW  = vtm_pkg::MUL_B_W;
	localparam int MPW  = vtm_pkg::MUL_P_W;
	localparam int NW   = vtm_pkg::NODE_W;
	localparam int VW   = vtm_pkg::VOX_W;
	localparam int RW   = vtm_pkg::RIDX_W;
	localparam int PLW  = vtm_pkg::PLANE_W;
	localparam int SW   = vtm_pkg::SPC_W;
	localparam int CNTW = vtm_pkg::CNT_W;
	localparam int PSW  = vtm_pkg::POS_W;
	localparam int GW   = vtm_pkg::GRAIN_W;
	localparam logic [3:0] LAST_REC = 4'(vtm_pkg::REC_PER_VOXEL - 1);
	localparam logic [3:0] FIRST_TET = 4'(vtm_pkg::VERTS_PER_VOXEL);

	// Control states, one-hot.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CALC = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	// Multiply sequence, one-hot; each step but the last issues one product, and each step
	// but the first stores the one from the step before.
	typedef enum logic [9:0] {
		ST_PLANE1  = 10'b00_0000_0001,
		ST_PLANE0  = 10'b00_0000_0010,
		ST_NODE_K  = 10'b00_0000_0100,
		ST_NODE_J  = 10'b00_0000_1000,
		ST_VOX_K   = 10'b00_0001_0000,
		ST_VOX_J   = 10'b00_0010_0000,
		ST_COORD_X = 10'b00_0100_0000,
		ST_COORD_Y = 10'b00_1000_0000,
		ST_COORD_Z = 10'b01_0000_0000,
		ST_FINISH  = 10'b10_0000_0000
	} step_t;

	state_t state_q;
	step_t  step_q;
	logic [3:0] rec_q;

	logic [CNTW-1:0] x_count_q, y_count_q, z_count_q;
	logic [SW-1:0]   x_spacing_q, y_spacing_q, z_spacing_q;
	logic [PW-1:0]   col_q, row_q, slice_q;

	logic signed [GW-1:0] grain_q;
	logic [PLW-1:0] plane1_q, plane0_q;
	logic [NW-1:0]  nbase_q;
	logic [VW-1:0]  vbase_q;
	logic [RW-1:0]  tidx_q;
	logic signed [PSW-1:0] cx0_q, cx1_q, cy0_q, cy1_q, cz0_q, cz1_q;

	logic [CW-1:0] nx, ny, nz, nx1, ny1;
	logic [MAW-1:0] mul_a;
	logic [MBW-1:0] mul_b;
	logic [MPW-1:0] prod;
	logic signed [PSW-1:0] c0_new, c1_new;

	logic in_take, out_free;
	logic [2:0] tet_t;
	logic rk_d, last_d;
	logic [RW-1:0] ridx_d;
	logic [NW-1:0] ca_d, cb_d, cc_d, cd_d;
	logic signed [PSW-1:0] px_d, py_d, pz_d;
	logic signed [GW-1:0] grain_d;

	// Count as used by the scan: zero acts as one, large values clamp to MAX_SIDE.
	function automatic logic [CW-1:0] eff_count(input logic [CNTW-1:0] c);
		if (c == '0) begin
			return CW'(1);
		end else if (c > CNTW'(MAX_SIDE)) begin
			return CW'(MAX_SIDE);
		end
		return c[CW-1:0];
	endfunction

	// Lattice node of corner c of the current voxel.
	function automatic logic [NW-1:0] node_of(input logic [2:0] c, input logic [NW-1:0] base,
			input logic [PLW-1:0] plane, input logic [CW-1:0] row_len);
		logic [NW-1:0] dz_off, dy_off;
		dz_off = c[2] ? NW'(plane) : '0;
		dy_off = c[1] ? NW'(row_len) : '0;
		return base + dz_off + dy_off + NW'(c[0]);
	endfunction

	assign nx  = eff_count(x_count_q);
	assign ny  = eff_count(y_count_q);
	assign nz  = eff_count(z_count_q);
	assign nx1 = nx + CW'(1);
	assign ny1 = ny + CW'(1);

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign in_take   = in_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid || !out_stall;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			ST_PLANE1: begin
				mul_a = MAW'(nx1);
				mul_b = MBW'(ny1);
			end
			ST_PLANE0: begin
				mul_a = MAW'(nx);
				mul_b = MBW'(ny);
			end
			ST_NODE_K: begin
				mul_a = MAW'(plane1_q);
				mul_b = MBW'(slice_q);
			end
			ST_NODE_J: begin
				mul_a = MAW'(nx1);
				mul_b = MBW'(row_q);
			end
			ST_VOX_K: begin
				mul_a = MAW'(plane0_q);
				mul_b = MBW'(slice_q);
			end
			ST_VOX_J: begin
				mul_a = MAW'(nx);
				mul_b = MBW'(row_q);
			end
			ST_COORD_X: begin
				mul_a = MAW'(col_q);
				mul_b = x_spacing_q;
			end
			ST_COORD_Y: begin
				mul_a = MAW'(row_q);
				mul_b = y_spacing_q;
			end
			ST_COORD_Z: begin
				mul_a = MAW'(slice_q);
				mul_b = z_spacing_q;
			end
			ST_FINISH: begin
				mul_a = '0;
				mul_b = '0;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	vtm_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Coordinate pair from p*spacing: the low corner is 2ps - s, the high one 2ps + s.
	always_comb begin
		logic [SW-1:0] spc;
		unique case (step_q)
			ST_COORD_Y: spc = x_spacing_q;
			ST_COORD_Z: spc = y_spacing_q;
			default:    spc = z_spacing_q;
		endcase
		c0_new = $signed({1'b0, prod[PSW-3:0], 1'b0}) - $signed(PSW'(spc));
		c1_new = $signed({1'b0, prod[PSW-3:0], 1'b0}) + $signed(PSW'(spc));
	end

	// Control: state, multiply step, record counter, scan position and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_PLANE1;
			rec_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			slice_q     <= '0;
			x_count_q   <= vtm_pkg::COUNT_RST;
			y_count_q   <= vtm_pkg::COUNT_RST;
			z_count_q   <= vtm_pkg::COUNT_RST;
			x_spacing_q <= vtm_pkg::SPACING_RST;
			y_spacing_q <= vtm_pkg::SPACING_RST;
			z_spacing_q <= vtm_pkg::SPACING_RST;
			out_valid   <= 1'b0;
		end else begin
			// Configuration writes; a listed register also restarts the scan.
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					vtm_pkg::REG_X_COUNT:   x_count_q   <= cfg_data[CNTW-1:0];
					vtm_pkg::REG_Y_COUNT:   y_count_q   <= cfg_data[CNTW-1:0];
					vtm_pkg::REG_Z_COUNT:   z_count_q   <= cfg_data[CNTW-1:0];
					vtm_pkg::REG_X_SPACING: x_spacing_q <= cfg_data[SW-1:0];
					vtm_pkg::REG_Y_SPACING: y_spacing_q <= cfg_data[SW-1:0];
					vtm_pkg::REG_Z_SPACING: z_spacing_q <= cfg_data[SW-1:0];
					default: ;
				endcase
				case (cfg_index) inside
					vtm_pkg::REG_X_COUNT, vtm_pkg::REG_Y_COUNT, vtm_pkg::REG_Z_COUNT,
					vtm_pkg::REG_X_SPACING, vtm_pkg::REG_Y_SPACING,
					vtm_pkg::REG_Z_SPACING: begin
						col_q   <= '0;
						row_q   <= '0;
						slice_q <= '0;
					end
					default: ;
				endcase
			end

			// The output register fills when a record is loaded and otherwise empties on a
			// transfer.
			if (state_q == S_EMIT && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_CALC;
						step_q  <= ST_PLANE1;
					end
				end
				S_CALC: begin
					if (step_q == ST_FINISH) begin
						state_q <= S_EMIT;
						rec_q   <= '0;
						step_q  <= ST_PLANE1;
						// Advance the raster position, x fastest.
						if ({1'b0, col_q} + CW'(1) < nx) begin
							col_q <= col_q + PW'(1);
						end else begin
							col_q <= '0;
							if ({1'b0, row_q} + CW'(1) < ny) begin
								row_q <= row_q + PW'(1);
							end else begin
								row_q <= '0;
								if ({1'b0, slice_q} + CW'(1) < nz) begin
									slice_q <= slice_q + PW'(1);
								end else begin
									slice_q <= '0;
								end
							end
						end
					end else begin
						step_q <= step_t'(step_q << 1);
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (rec_q == LAST_REC) begin
							state_q <= S_IDLE;
						end else begin
							rec_q <= rec_q + 4'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: each step after the first stores the product issued in the step before it.
	always_ff @(posedge clk) begin
		if (in_take) begin
			grain_q <= grain_label;
		end
		if (state_q == S_CALC) begin
			unique case (step_q)
				ST_PLANE0:  plane1_q <= prod[PLW-1:0];
				ST_NODE_K:  plane0_q <= prod[PLW-1:0];
				ST_NODE_J:  nbase_q  <= prod[NW-1:0] + NW'(col_q);
				ST_VOX_K:   nbase_q  <= nbase_q + prod[NW-1:0];
				ST_VOX_J:   vbase_q  <= prod[VW-1:0] + VW'(col_q);
				ST_COORD_X: vbase_q  <= vbase_q + prod[VW-1:0];
				ST_COORD_Y: begin
					cx0_q  <= c0_new;
					cx1_q  <= c1_new;
					tidx_q <= (RW'(vbase_q) << 2) + (RW'(vbase_q) << 1);
				end
				ST_COORD_Z: begin
					cy0_q <= c0_new;
					cy1_q <= c1_new;
				end
				ST_FINISH: begin
					cz0_q <= c0_new;
					cz1_q <= c1_new;
				end
				default: ;
			endcase
		end
	end

	// Contents of the record selected by the record counter.
	assign tet_t = 3'(rec_q - FIRST_TET);

	always_comb begin
		rk_d    = vtm_pkg::KIND_VERTEX;
		ridx_d  = '0;
		ca_d    = '0;
		cb_d    = '0;
		cc_d    = '0;
		cd_d    = '0;
		px_d    = '0;
		py_d    = '0;
		pz_d    = '0;
		grain_d = '0;
		last_d  = 1'b0;
		if (rec_q < FIRST_TET) begin
			ridx_d = RW'(node_of(rec_q[2:0], nbase_q, plane1_q, nx1));
			px_d   = rec_q[0] ? cx1_q : cx0_q;
			py_d   = rec_q[1] ? cy1_q : cy0_q;
			pz_d   = rec_q[2] ? cz1_q : cz0_q;
		end else begin
			rk_d    = vtm_pkg::KIND_TET;
			ridx_d  = tidx_q + RW'(tet_t);
			ca_d    = node_of(vtm_pkg::tet_corner(tet_t, 2'd0), nbase_q, plane1_q, nx1);
			cb_d    = node_of(vtm_pkg::tet_corner(tet_t, 2'd1), nbase_q, plane1_q, nx1);
			cc_d    = node_of(vtm_pkg::tet_corner(tet_t, 2'd2), nbase_q, plane1_q, nx1);
			cd_d    = node_of(vtm_pkg::tet_corner(tet_t, 2'd3), nbase_q, plane1_q, nx1);
			grain_d = grain_q;
			last_d  = (rec_q == LAST_REC);
		end
	end

	// Output register, loaded while records are emitted whenever it is empty or its record is being transferred.
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			record_kind   <= rk_d;
			record_index  <= ridx_d;
			corner_a      <= ca_d;
			corner_b      <= cb_d;
			corner_c      <= cc_d;
			corner_d      <= cd_d;
			pos_x         <= px_d;
			pos_y         <= py_d;
			pos_z         <= pz_d;
			tet_grain     <= grain_d;
			last_of_voxel <= last_d;
		end
	end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the voxel mesher: directed and random voxels under varied flow control.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Widths and limits taken from the shared package.
	localparam int IDX_W        = vtm_pkg::IDX_W;
	localparam int GRAIN_W      = vtm_pkg::GRAIN_W;
	localparam int RIDX_W       = vtm_pkg::RIDX_W;
	localparam int NODE_W       = vtm_pkg::NODE_W;
	localparam int POS_W        = vtm_pkg::POS_W;
	localparam int CNT_W        = vtm_pkg::CNT_W;
	localparam int SPC_W        = vtm_pkg::SPC_W;
	localparam int CFG_W        = vtm_pkg::CFG_W;
	localparam int MAX_SIDE_DEF = vtm_pkg::MAX_SIDE_DEF;

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 600;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_WAIT  = 30;
	localparam int BURST_ITEMS = 35;

	// Register indexes past the end of the register list; writes there change nothing.
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Corners of the six tetrahedra around the diagonal from corner 1 to corner 6.
	localparam int TET_CORNERS [6][4] = '{
		'{0, 1, 2, 6}, '{1, 3, 2, 6}, '{0, 1, 6, 4},
		'{1, 3, 6, 7}, '{1, 4, 5, 6}, '{5, 7, 1, 6}
	};

	// Grain ids at the edges of the signed range and alternating bit patterns.
	localparam logic [GRAIN_W-1:0] EDGE_GRAINS [6] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
		32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
	};

	typedef struct packed {
		logic                      kind;
		logic [RIDX_W-1:0]         rec_index;
		logic [NODE_W-1:0]         corner_a;
		logic [NODE_W-1:0]         corner_b;
		logic [NODE_W-1:0]         corner_c;
		logic [NODE_W-1:0]         corner_d;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [POS_W-1:0]   pos_z;
		logic signed [GRAIN_W-1:0] grain;
		logic                      last;
	} mesh_record_t;

	// Tracks grid settings and scan position, and holds the records each voxel must produce.
	class mesh_scoreboard;
		logic [CNT_W-1:0] x_cnt, y_cnt, z_cnt;
		logic [SPC_W-1:0] x_sp, y_sp, z_sp;
		longint col, row, slice;
		mesh_record_t expected_records[$];
		int failures;

		function new();
			x_cnt = vtm_pkg::COUNT_RST;
			y_cnt = vtm_pkg::COUNT_RST;
			z_cnt = vtm_pkg::COUNT_RST;
			x_sp = vtm_pkg::SPACING_RST;
			y_sp = vtm_pkg::SPACING_RST;
			z_sp = vtm_pkg::SPACING_RST;
			col = 0;
			row = 0;
			slice = 0;
			failures = 0;
		endfunction

		// A count of zero behaves as one and anything past the largest side is clipped.
		function longint grid_side(logic [CNT_W-1:0] c);
			if (c == 0)
				return 1;
			if (c > MAX_SIDE_DEF)
				return longint'(MAX_SIDE_DEF);
			return longint'(c);
		endfunction

		// Coordinate of lattice plane p is (2p-1) times the spacing, kept to the port width.
		function logic signed [POS_W-1:0] corner_pos(longint p, logic [SPC_W-1:0] sp);
			longint v;
			v = (2 * p - 1) * longint'(sp);
			return v[POS_W-1:0];
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				vtm_pkg::REG_X_COUNT:   x_cnt = val[CNT_W-1:0];
				vtm_pkg::REG_Y_COUNT:   y_cnt = val[CNT_W-1:0];
				vtm_pkg::REG_Z_COUNT:   z_cnt = val[CNT_W-1:0];
				vtm_pkg::REG_X_SPACING: x_sp = val[SPC_W-1:0];
				vtm_pkg::REG_Y_SPACING: y_sp = val[SPC_W-1:0];
				vtm_pkg::REG_Z_SPACING: z_sp = val[SPC_W-1:0];
				default:                return;
			endcase
			// Any write to a real register starts the scan over.
			col = 0;
			row = 0;
			slice = 0;
		endfunction

		// Queues the eight corner vertices and six tetrahedra of the voxel at the scan position.
		function void note_voxel(logic signed [GRAIN_W-1:0] grain);
			longint nx, ny, nz, voxel, dx, dy, dz, tet_idx;
			longint node [8];
			mesh_record_t rec;
			int c, t;
			nx = grid_side(x_cnt);
			ny = grid_side(y_cnt);
			nz = grid_side(z_cnt);
			voxel = slice * nx * ny + row * nx + col;
			for (c = 0; c < 8; c++) begin
				dx = longint'(c & 1);
				dy = longint'((c >> 1) & 1);
				dz = longint'((c >> 2) & 1);
				node[c] = (slice + dz) * (nx + 1) * (ny + 1) + (row + dy) * (nx + 1) + col + dx;
				rec = '0;
				rec.kind = vtm_pkg::KIND_VERTEX;
				rec.rec_index = node[c][RIDX_W-1:0];
				rec.pos_x = corner_pos(col + dx, x_sp);
				rec.pos_y = corner_pos(row + dy, y_sp);
				rec.pos_z = corner_pos(slice + dz, z_sp);
				expected_records.push_back(rec);
			end
			for (t = 0; t < 6; t++) begin
				tet_idx = 6 * voxel + longint'(t);
				rec = '0;
				rec.kind = vtm_pkg::KIND_TET;
				rec.rec_index = tet_idx[RIDX_W-1:0];
				rec.corner_a = node[TET_CORNERS[t][0]][NODE_W-1:0];
				rec.corner_b = node[TET_CORNERS[t][1]][NODE_W-1:0];
				rec.corner_c = node[TET_CORNERS[t][2]][NODE_W-1:0];
				rec.corner_d = node[TET_CORNERS[t][3]][NODE_W-1:0];
				rec.grain = grain;
				rec.last = (t == 5);
				expected_records.push_back(rec);
			end
			// Raster order: x fastest, wrapping back to the first voxel after the last.
			if (col + 1 < nx) begin
				col++;
			end else begin
				col = 0;
				if (row + 1 < ny) begin
					row++;
				end else begin
					row = 0;
					slice = (slice + 1 < nz) ? slice + 1 : 0;
				end
			end
		endfunction

		function void report(string what, logic [63:0] want, logic [63:0] got);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("mismatch in %s: expected %0h, got %0h", what, want, got);
		endfunction

		// Compares one received record against the oldest pending one, field by field.
		function void check_record(mesh_record_t got);
			mesh_record_t want;
			if (expected_records.size() == 0) begin
				report("record with none pending", '0, 64'(got.rec_index));
				return;
			end
			want = expected_records.pop_front();
			if (got.kind !== want.kind)
				report("record_kind", 64'(want.kind), 64'(got.kind));
			if (got.rec_index !== want.rec_index)
				report("record_index", 64'(want.rec_index), 64'(got.rec_index));
			if (got.corner_a !== want.corner_a)
				report("corner_a", 64'(want.corner_a), 64'(got.corner_a));
			if (got.corner_b !== want.corner_b)
				report("corner_b", 64'(want.corner_b), 64'(got.corner_b));
			if (got.corner_c !== want.corner_c)
				report("corner_c", 64'(want.corner_c), 64'(got.corner_c));
			if (got.corner_d !== want.corner_d)
				report("corner_d", 64'(want.corner_d), 64'(got.corner_d));
			if (got.pos_x !== want.pos_x)
				report("pos_x", 64'(want.pos_x), 64'(got.pos_x));
			if (got.pos_y !== want.pos_y)
				report("pos_y", 64'(want.pos_y), 64'(got.pos_y));
			if (got.pos_z !== want.pos_z)
				report("pos_z", 64'(want.pos_z), 64'(got.pos_z));
			if (got.grain !== want.grain)
				report("tet_grain", 64'(want.grain), 64'(got.grain));
			if (got.last !== want.last)
				report("last_of_voxel", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [IDX_W-1:0]           cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;

	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [GRAIN_W-1:0]  grain_label = '0;

	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       record_kind;
	logic [RIDX_W-1:0]          record_index;
	logic [NODE_W-1:0]          corner_a;
	logic [NODE_W-1:0]          corner_b;
	logic [NODE_W-1:0]          corner_c;
	logic [NODE_W-1:0]          corner_d;
	logic signed [POS_W-1:0]    pos_x;
	logic signed [POS_W-1:0]    pos_y;
	logic signed [POS_W-1:0]    pos_z;
	logic signed [GRAIN_W-1:0]  tet_grain;
	logic                       last_of_voxel;

	int idle_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;
	logic hold_active = 1'b0;
	event hold_off;

	mesh_scoreboard sb = new();

	voxel_to_tetrahedra_mesher_unit u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: check every completed transfer, then choose the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_record({record_kind, record_index, corner_a, corner_b, corner_c, corner_d,
				pos_x, pos_y, pos_z, tet_grain, last_of_voxel});
		out_stall <= hold_active || ($urandom_range(99) < stall_pct);
	end

	// Long output hold-off, counted here so the sender keeps offering voxels meanwhile.
	always begin
		@(hold_off);
		@(negedge clk);
		hold_active = 1'b1;
		repeat (LONG_HOLD) @(negedge clk);
		hold_active = 1'b0;
	end

	// One register transfer; valid is dropped only after the last write of a group.
	task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
			input bit drop_valid);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		if (drop_valid)
			cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_W-1:0] xc, input logic [CFG_W-1:0] yc,
			input logic [CFG_W-1:0] zc, input logic [CFG_W-1:0] xs,
			input logic [CFG_W-1:0] ys, input logic [CFG_W-1:0] zs);
		write_cfg(vtm_pkg::REG_X_COUNT, xc, 1'b0);
		write_cfg(vtm_pkg::REG_Y_COUNT, yc, 1'b0);
		write_cfg(vtm_pkg::REG_Z_COUNT, zc, 1'b0);
		write_cfg(vtm_pkg::REG_X_SPACING, xs, 1'b0);
		write_cfg(vtm_pkg::REG_Y_SPACING, ys, 1'b0);
		write_cfg(vtm_pkg::REG_Z_SPACING, zs, 1'b1);
	endtask

	// Offers one voxel, possibly after an idle gap, and waits for its transfer.
	task automatic send_voxel(input logic signed [GRAIN_W-1:0] grain);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 120) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		grain_label <= grain;
		do @(posedge clk); while (in_stall);
		sb.note_voxel(grain);
	endtask

	// Stops offering voxels and waits until every pending record has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_records.size() != 0)
			@(posedge clk);
	endtask

	// Count words with junk above the count bits; mostly small grids so the scan wraps.
	function automatic logic [CFG_W-1:0] rand_count();
		logic [CFG_W-1:0] w;
		w = CFG_W'($urandom);
		case ($urandom_range(9))
			0:       w[CNT_W-1:0] = '0;
			1:       w[CNT_W-1:0] = '1;
			2:       w[CNT_W-1:0] = CNT_W'(MAX_SIDE_DEF);
			3:       w[CNT_W-1:0] = CNT_W'($urandom_range(MAX_SIDE_DEF + 1, 2047));
			default: w[CNT_W-1:0] = CNT_W'($urandom_range(1, 4));
		endcase
		return w;
	endfunction

	function automatic logic [CFG_W-1:0] rand_spacing();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2:       return 24'd1;
			default: return CFG_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [GRAIN_W-1:0] rand_grain();
		if ($urandom_range(7) == 0)
			return EDGE_GRAINS[$urandom_range(5)];
		return $urandom;
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a single-voxel grid, every voxel lands at the origin.
		foreach (EDGE_GRAINS[i])
			send_voxel(EDGE_GRAINS[i]);
		wait_drained();

		// Count of zero, oversized count, widest and zero spacing.
		configure(24'hFFF800, 24'h0007FF, 24'h000002, 24'hFFFFFF, 24'h000000, 24'h000001);
		repeat (6)
			send_voxel(rand_grain());
		wait_drained();
		// Writes past the register list must not restart the scan.
		write_cfg(REG_SPARE_HI, 24'hFFFFFF, 1'b1);
		write_cfg(REG_SPARE_LO, 24'h000000, 1'b1);
		repeat (4)
			send_voxel(rand_grain());
		wait_drained();

		// Largest grid on every axis.
		configure(24'h000400, 24'h000400, 24'h000400, 24'h000001, 24'hFFFFFF, 24'h800000);
		repeat (3)
			send_voxel(rand_grain());
		wait_drained();

		// Small grid that wraps back to the first voxel.
		configure(24'h000002, 24'h000001, 24'h000002, 24'h012345, 24'h00ABCD, 24'h7FFFFF);
		repeat (5)
			send_voxel(rand_grain());
		wait_drained();

		// Random phases under each flow-control mix.
		for (int mode = 0; mode < 4; mode++) begin
			for (int part = 0; part < 2; part++) begin
				wait_drained();
				configure(rand_count(), rand_count(), rand_count(),
					rand_spacing(), rand_spacing(), rand_spacing());
				case (mode)
					0: begin idle_pct = 0;  stall_pct = 0;  end
					1: begin idle_pct = 70; stall_pct = 0;  end
					2: begin idle_pct = 0;  stall_pct = 70; end
					default: begin idle_pct = 28; stall_pct = 28; end
				endcase
				for (int n = 0; n < BURST_ITEMS; n++) begin
					if (mode == 0 && part == 0 && n == 3)
						-> hold_off;
					if (mode == 3 && part == 1 && n == BURST_ITEMS / 2) begin
						wait_drained();
						write_cfg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
							CFG_W'($urandom), 1'b1);
					end
					send_voxel(rand_grain());
				end
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.failures == 0 && sb.expected_records.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
